### design/wris_pkg.sv
`default_nettype none

package wris_pkg;

    localparam int ENTRIES      = 64;
    localparam int IDX_BITS     = 6;
    localparam int CNT_BITS     = 7;
    localparam int WEIGHT_BITS  = 8;
    localparam int RANDOM_BITS  = 16;
    localparam int TOTAL_BITS   = 14;
    localparam int FUNC_BITS    = 2;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_WEIGHT     = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_WEIGHT     = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ENTRIES_IN_USE = 2'd2;

    typedef enum logic [FUNC_BITS-1:0] {
        FUNC_WRITE = 2'd0,
        FUNC_DRAW  = 2'd1,
        FUNC_TEST  = 2'd2
    } func_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_WR,
        ST_RD_TEST,
        ST_WRITE,
        ST_TEST,
        ST_SUM,
        ST_MUL,
        ST_SCAN
    } state_t;

    localparam state_t ST_LAST = ST_SCAN;

    typedef struct packed {
        logic load_item;
        logic rd_slot;
        logic write_entry;
        logic test;
        logic step;
        logic mul;
        logic take_index;
        logic take_last;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic scan_done;
        logic scan_hit;
        logic total_zero;
        logic full_range;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

### design/weighted_random_index_selector.sv
`default_nettype none

// Weighted random index selector: a 64-entry table of 8-bit weights, cleared at reset, serving
// one item at a time. Func 0 writes a weight clamped to [min_weight, max_weight]; func 1 draws
// the first index whose running sum exceeds (total * random_fraction) >> 16, 0 when the total
// is zero; func 2 reports hit when random_fraction * (max - min) < weight << 16. Writes and
// tests read the slot, then finish and register the result. A draw reads the table once per
// cycle through its single read port: with all 64 entries in use it scans up to the chosen
// index k, using the running table total; with fewer entries n in use a summing pass over
// the n entries comes first. Function code 3 returns zeros. A result still waiting in the
// output register holds the next item in its last cycle. Configuration writes take effect
// at once and must be made while no item is in progress.
module weighted_random_index_selector import wris_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0] cfg_wr_index,
    input  logic [WEIGHT_BITS-1:0]  cfg_wr_data,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [FUNC_BITS-1:0]    s_func,
    input  logic [IDX_BITS-1:0]     s_slot,
    input  logic [WEIGHT_BITS-1:0]  s_weight,
    input  logic [RANDOM_BITS-1:0]  s_random_fraction,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [IDX_BITS-1:0]     m_chosen_index,
    output logic                    m_hit
);

    cmd_t    cmd;
    status_t status;

    wris_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_func  (s_func),
        .status  (status),
        .cmd     (cmd)
    );

    wris_dp u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_index      (cfg_wr_index),
        .cfg_wr_data       (cfg_wr_data),
        .s_slot            (s_slot),
        .s_weight          (s_weight),
        .s_random_fraction (s_random_fraction),
        .cmd               (cmd),
        .status            (status),
        .m_ready           (m_ready),
        .m_valid           (m_valid),
        .m_chosen_index    (m_chosen_index),
        .m_hit             (m_hit)
    );

endmodule

`default_nettype wire

### design/wris_ctrl.sv
`default_nettype none

module wris_ctrl import wris_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [FUNC_BITS-1:0] s_func,
    input  status_t              status,
    output cmd_t                 cmd
);

    state_t state_reg;
    state_t state_next;
    logic   finish_now;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // the final state of each operation hands its result over once the output is free
    always_comb begin
        finish_now = 1'b0;
        case (state_reg)
            ST_WRITE, ST_TEST: begin
                finish_now = status.out_free;
            end
            ST_MUL: begin
                finish_now = status.total_zero && status.out_free;
            end
            ST_SCAN: begin
                finish_now = (status.scan_hit || status.scan_done) && status.out_free;
            end
            default: begin
                finish_now = 1'b0;
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    case (s_func)
                        FUNC_WRITE: state_next = ST_RD_WR;
                        FUNC_TEST:  state_next = ST_RD_TEST;
                        FUNC_DRAW:  state_next = status.full_range ? ST_MUL : ST_SUM;
                        default:    state_next = ST_WRITE;
                    endcase
                end
            end
            ST_RD_WR: begin
                state_next = ST_WRITE;
            end
            ST_RD_TEST: begin
                state_next = ST_TEST;
            end
            ST_SUM: begin
                if (status.scan_done) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                if (!status.total_zero) begin
                    state_next = ST_SCAN;
                end else if (finish_now) begin
                    state_next = ST_IDLE;
                end
            end
            ST_WRITE, ST_TEST, ST_SCAN: begin
                if (finish_now) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // unused function code goes through ST_WRITE with writes suppressed
    logic item_is_write_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_is_write_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            item_is_write_reg <= (s_func == FUNC_WRITE);
        end
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready       = 1'b1;
                cmd.load_item = s_valid;
            end
            ST_RD_WR, ST_RD_TEST: begin
                cmd.rd_slot = 1'b1;
            end
            ST_WRITE: begin
                cmd.write_entry = finish_now && item_is_write_reg;
                cmd.load_out    = finish_now;
            end
            ST_TEST: begin
                cmd.test     = finish_now;
                cmd.load_out = finish_now;
            end
            ST_SUM: begin
                cmd.step = !status.scan_done;
            end
            ST_MUL: begin
                cmd.mul      = !status.total_zero;
                cmd.load_out = finish_now;
            end
            ST_SCAN: begin
                cmd.take_index = finish_now && status.scan_hit;
                cmd.take_last  = finish_now && !status.scan_hit;
                cmd.load_out   = finish_now;
                cmd.step       = !status.scan_hit && !status.scan_done;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg != ST_IDLE))
        else $error("accepted item left controller idle");

    a_single_action: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.write_entry, cmd.mul, cmd.take_index, cmd.take_last, cmd.step}))
        else $error("conflicting datapath commands");

    a_result_once: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |=> (state_reg == ST_IDLE))
        else $error("result handed over without returning idle");

endmodule

`default_nettype wire

### design/wris_dp.sv
`default_nettype none

module wris_dp import wris_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0] cfg_wr_index,
    input  logic [WEIGHT_BITS-1:0]  cfg_wr_data,
    input  logic [IDX_BITS-1:0]     s_slot,
    input  logic [WEIGHT_BITS-1:0]  s_weight,
    input  logic [RANDOM_BITS-1:0]  s_random_fraction,
    input  cmd_t                    cmd,
    output status_t                 status,
    input  logic                    m_ready,
    output logic                    m_valid,
    output logic [IDX_BITS-1:0]     m_chosen_index,
    output logic                    m_hit
);

    localparam int PROD_BITS  = TOTAL_BITS + RANDOM_BITS;
    localparam int RANGE_BITS = WEIGHT_BITS + 1;
    localparam int CMP_BITS   = RANDOM_BITS + 1 + RANGE_BITS;

    logic [IDX_BITS-1:0]    slot_reg;
    logic [WEIGHT_BITS-1:0] weight_reg;
    logic [RANDOM_BITS-1:0] rand_reg;

    logic [WEIGHT_BITS-1:0] min_reg;
    logic [WEIGHT_BITS-1:0] max_reg;
    logic [CNT_BITS-1:0]    n_reg;
    logic [CNT_BITS-1:0]    n_wr;

    logic [WEIGHT_BITS-1:0] mem [ENTRIES];
    logic [ENTRIES-1:0]     valid_reg;
    logic [WEIGHT_BITS-1:0] rd_data_reg;
    logic                   rd_valid_reg;
    logic [IDX_BITS-1:0]    rd_addr;
    logic                   rd_en;
    logic [WEIGHT_BITS-1:0] rd_val;

    logic [TOTAL_BITS-1:0]  total_reg;
    logic [TOTAL_BITS-1:0]  acc_reg;
    logic [TOTAL_BITS-1:0]  dec_reg;
    logic [CNT_BITS-1:0]    cnt_reg;
    logic                   pend_reg;

    logic [IDX_BITS-1:0]    res_index_reg;
    logic                   res_hit_reg;
    logic                   m_valid_reg;
    logic [IDX_BITS-1:0]    out_index_reg;
    logic                   out_hit_reg;

    logic [WEIGHT_BITS-1:0]      w_clamped;
    logic [TOTAL_BITS-1:0]       total_src;
    logic [PROD_BITS-1:0]        prod;
    logic [TOTAL_BITS-1:0]       run_sum;
    logic                        scan_issue;
    logic [CNT_BITS-1:0]         cnt_prev;
    logic [CNT_BITS-1:0]         n_prev;
    logic signed [RANGE_BITS-1:0] range_s;
    logic signed [CMP_BITS-1:0]  lhs;
    logic signed [CMP_BITS-1:0]  rhs;
    logic                        hit_calc;

    // configuration
    always_comb begin
        n_wr = cfg_wr_data[CNT_BITS-1:0];
        if (n_wr == '0) begin
            n_wr = CNT_BITS'(1);
        end else if (n_wr > CNT_BITS'(ENTRIES)) begin
            n_wr = CNT_BITS'(ENTRIES);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_reg <= '0;
            max_reg <= '1;
            n_reg   <= CNT_BITS'(ENTRIES);
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                CFG_MIN_WEIGHT:     min_reg <= cfg_wr_data;
                CFG_MAX_WEIGHT:     max_reg <= cfg_wr_data;
                CFG_ENTRIES_IN_USE: n_reg   <= n_wr;
                default:            ;
            endcase
        end
    end

    // item capture
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            slot_reg   <= s_slot;
            weight_reg <= s_weight;
            rand_reg   <= s_random_fraction;
        end
    end

    // weight table, entries without a valid bit read as zero
    assign rd_addr = cmd.rd_slot ? slot_reg : cnt_reg[IDX_BITS-1:0];
    assign rd_en   = cmd.rd_slot || cmd.step;
    assign rd_val  = rd_valid_reg ? rd_data_reg : '0;

    always_comb begin
        if (weight_reg < min_reg) begin
            w_clamped = min_reg;
        end else if (weight_reg > max_reg) begin
            w_clamped = max_reg;
        end else begin
            w_clamped = weight_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.write_entry) begin
            mem[slot_reg] <= w_clamped;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
            total_reg    <= '0;
        end else begin
            if (rd_en) begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
            if (cmd.write_entry) begin
                valid_reg[slot_reg] <= 1'b1;
                total_reg <= total_reg - TOTAL_BITS'(rd_val) + TOTAL_BITS'(w_clamped);
            end
        end
    end

    // sum and prefix scan
    assign scan_issue = (cnt_reg < n_reg);
    assign run_sum    = acc_reg + TOTAL_BITS'(rd_val);
    assign total_src  = status.full_range ? total_reg : acc_reg;
    assign prod       = PROD_BITS'(total_src) * PROD_BITS'(rand_reg);
    assign cnt_prev   = cnt_reg - 1'b1;
    assign n_prev     = n_reg - 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            pend_reg <= 1'b0;
            acc_reg  <= '0;
        end else if (cmd.load_item || cmd.mul) begin
            cnt_reg  <= '0;
            pend_reg <= 1'b0;
            acc_reg  <= '0;
        end else if (cmd.step) begin
            pend_reg <= scan_issue;
            if (scan_issue) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (pend_reg) begin
                acc_reg <= run_sum;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.mul) begin
            dec_reg <= prod[PROD_BITS-1:RANDOM_BITS];
        end
    end

    // bernoulli compare
    assign range_s  = $signed({1'b0, max_reg}) - $signed({1'b0, min_reg});
    assign lhs      = $signed({1'b0, rand_reg}) * range_s;
    assign rhs      = $signed(CMP_BITS'({rd_val, {RANDOM_BITS{1'b0}}}));
    assign hit_calc = (lhs < rhs);

    // results
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            res_index_reg <= '0;
            res_hit_reg   <= 1'b0;
        end else begin
            if (cmd.test) begin
                res_hit_reg <= hit_calc;
            end
            if (cmd.take_index) begin
                res_index_reg <= cnt_prev[IDX_BITS-1:0];
            end else if (cmd.take_last) begin
                res_index_reg <= n_prev[IDX_BITS-1:0];
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // results taken straight from the compare and scan in the finishing cycle
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            if (cmd.take_index) begin
                out_index_reg <= cnt_prev[IDX_BITS-1:0];
            end else if (cmd.take_last) begin
                out_index_reg <= n_prev[IDX_BITS-1:0];
            end else begin
                out_index_reg <= res_index_reg;
            end
            out_hit_reg <= cmd.test ? hit_calc : res_hit_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_chosen_index = out_index_reg;
    assign m_hit          = out_hit_reg;

    assign status.scan_done  = !pend_reg && (cnt_reg == n_reg);
    assign status.scan_hit   = pend_reg && (run_sum > dec_reg);
    assign status.total_zero = (total_src == '0);
    assign status.full_range = (n_reg == CNT_BITS'(ENTRIES));
    assign status.out_free   = !m_valid_reg || m_ready;

    a_hit_on_fresh_data: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.take_index |-> pend_reg)
        else $error("scan hit without a pending table read");

    a_write_needs_free_output: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> status.out_free)
        else $error("output overwritten before it was taken");

    a_scan_within_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.step |-> (cnt_reg <= n_reg))
        else $error("scan ran past the entries in use");

endmodule

`default_nettype wire
